FILE: rtl/core/lfbf_pkg.sv
// ----------------------------------------------------------------------------
// lfbf_pkg
// shared types and constants of the lidar footprint box filter
// ----------------------------------------------------------------------------
package lfbf_pkg;

  // field widths
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned INTEN_W  = 16;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // cordic datapath: x and y in mm with 16 fraction bits plus gain growth,
  // z in 2^32 units per turn plus headroom
  localparam int unsigned XY_W   = 36;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned ATAN_LEN = 24;

  // gain multiply, one 4-bit digit of x (or y) per cycle, lsb first
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned DIGITS   = XY_W / DIGIT_W;
  localparam int unsigned DCNT_W   = 4;
  localparam int unsigned GAIN_W   = 37;
  localparam int unsigned ACC_W    = 42;
  // gain 0.6072529350 in q30, pre-shifted by 6 so that nine digit shifts
  // leave the product scaled by 2^-30
  localparam logic signed [GAIN_W-1:0] GAIN_SHIFTED = 37'sd652032874 <<< 6;

  // range kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_FINITE  = 2'd0,
    KIND_POS_INF = 2'd1,
    KIND_NEG_INF = 2'd2,
    KIND_NAN     = 2'd3
  } range_kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT     = 3'd0,
    REG_REAR      = 3'd1,
    REG_LEFT      = 3'd2,
    REG_RIGHT     = 3'd3,
    REG_START_ANG = 3'd4,
    REG_ANG_STEP  = 3'd5,
    REG_MIN_RANGE = 3'd6,
    REG_MAX_RANGE = 3'd7
  } cfg_reg_t;

  // reset values of the registers
  localparam logic [RANGE_W-1:0] FRONT_RST     = 16'd450;
  localparam logic [RANGE_W-1:0] REAR_RST      = 16'd250;
  localparam logic [RANGE_W-1:0] LEFT_RST      = 16'd250;
  localparam logic [RANGE_W-1:0] RIGHT_RST     = 16'd250;
  localparam logic [ANGLE_W-1:0] START_ANG_RST = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANG_STEP_RST  = 16'd182;
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 16'd0;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_CHK,
    ST_SEND
  } state_t;

  // arctangent of 2^-i in 2^32 units per turn
  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/lidar_footprint_box_filter.sv
// ----------------------------------------------------------------------------
// lidar_footprint_box_filter
// clears lidar beams whose point falls inside the robot footprint rectangle
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | flow control
//  --------+------------------------------------------------+-------------
//  cfg     | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//  in      | in_range_mm, in_range_kind, in_intensity,      | in_valid / in_stall
//          | in_scan_end                                    |
//  out     | out_range_mm, out_range_kind, out_intensity,   | out_valid / out_stall
//          | out_scan_end                                   |
//
// a beam that is tested runs the cordic rotation, one iteration per cycle,
// then the 4-bit serial gain multiply and the box check before its result
// shows; an untested beam shows in the next cycle.
// one beam is in flight at a time; the next request is taken in the cycle
// after the result leaves.
// rst_n is synchronous and active low; it restores the register defaults
// and restarts the beam angle at start_angle.
// out_stall holds the result in its output register as long as it is high.

module lidar_footprint_box_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data,
  // beam requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lfbf_pkg::RANGE_W-1:0]       in_range_mm,
  input  logic [lfbf_pkg::KIND_W-1:0]        in_range_kind,
  input  logic [lfbf_pkg::INTEN_W-1:0]       in_intensity,
  input  logic                               in_scan_end,
  // filtered beams
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lfbf_pkg::RANGE_W-1:0]       out_range_mm,
  output logic [lfbf_pkg::KIND_W-1:0]        out_range_kind,
  output logic [lfbf_pkg::INTEN_W-1:0]       out_intensity,
  output logic                               out_scan_end
);

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam int unsigned XY_W  = lfbf_pkg::XY_W;
  localparam int unsigned Z_W   = lfbf_pkg::Z_W;
  localparam int unsigned ACC_W = lfbf_pkg::ACC_W;
  // gain sign-extended to the accumulator width
  localparam logic signed [ACC_W-1:0] GAIN_ACC = ACC_W'(lfbf_pkg::GAIN_SHIFTED);

  // configuration registers
  logic [15:0] front_r, rear_r, left_r, right_r;
  logic [15:0] start_ang_r, ang_step_r, min_range_r, max_range_r;

  // beam angle state
  logic [15:0] offset_r;

  // control
  lfbf_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   rot_cnt_r;
  logic [lfbf_pkg::DCNT_W-1:0] mul_cnt_r;
  logic               flip_r;

  // cordic and multiply datapath; x_r and y_r shift out one digit per
  // cycle once the rotation is done
  logic signed [XY_W-1:0]  x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;

  // result register
  logic [lfbf_pkg::RANGE_W-1:0] out_range_mm_r;
  logic [lfbf_pkg::KIND_W-1:0]  out_range_kind_r;
  logic [lfbf_pkg::INTEN_W-1:0] out_intensity_r;
  logic                         out_scan_end_r;

  logic in_acc;
  logic out_acc;
  logic test_beam;
  logic rot_last;
  logic mul_last;

  // beam angle and half-turn fold
  logic [15:0] beam_ang;
  logic [15:0] ang_quarter;
  logic        flip;
  logic [15:0] ang_folded;

  // cordic step
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_s;
  logic signed [XY_W-1:0] x_step, y_step;
  logic signed [Z_W-1:0]  z_step;

  // serial gain multiply
  logic signed [4:0]       dig_x, dig_y;
  logic signed [ACC_W-1:0] prod_x, prod_y;
  logic signed [ACC_W-1:0] sum_x, sum_y;

  // box test
  logic signed [ACC_W-1:0] lim_front, lim_rear, lim_left, lim_right;
  logic                    in_box;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != lfbf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == lfbf_pkg::ST_SEND);
  assign out_acc   = out_valid && !out_stall;

  assign out_range_mm   = out_range_mm_r;
  assign out_range_kind = out_range_kind_r;
  assign out_intensity  = out_intensity_r;
  assign out_scan_end   = out_scan_end_r;

  // only finite beams inside the range window are rotated
  assign test_beam = (in_range_kind == lfbf_pkg::KIND_FINITE) &&
                     (in_range_mm >= min_range_r) && (in_range_mm <= max_range_r);

  assign rot_last = (rot_cnt_r == CNT_W'(CORDIC_STEPS - 1));
  assign mul_last = (mul_cnt_r == lfbf_pkg::DCNT_W'(lfbf_pkg::DIGITS - 1));

  // fold the angle into the quarter turns on either side of zero
  assign beam_ang    = start_ang_r + offset_r;
  assign ang_quarter = beam_ang + 16'h4000;
  assign flip        = ang_quarter[15];
  assign ang_folded  = flip ? (beam_ang ^ 16'h8000) : beam_ang;

  // one cordic micro-rotation; arithmetic shifts round toward minus infinity
  assign dx     = y_r >>> rot_cnt_r;
  assign dy     = x_r >>> rot_cnt_r;
  assign atan_s = signed'({2'b00, lfbf_pkg::atan_turn32(5'(rot_cnt_r))});
  always_comb begin
    if (!z_r[Z_W-1]) begin
      x_step = x_r - dx;
      y_step = y_r + dy;
      z_step = z_r - atan_s;
    end else begin
      x_step = x_r + dx;
      y_step = y_r - dy;
      z_step = z_r + atan_s;
    end
  end

  // gain multiply: low digits unsigned, top digit carries the sign;
  // the half-turn negation is folded in as a subtract
  assign dig_x  = mul_last ? signed'({x_r[3], x_r[3:0]}) : signed'({1'b0, x_r[3:0]});
  assign dig_y  = mul_last ? signed'({y_r[3], y_r[3:0]}) : signed'({1'b0, y_r[3:0]});
  assign prod_x = ACC_W'(dig_x) * GAIN_ACC;
  assign prod_y = ACC_W'(dig_y) * GAIN_ACC;
  assign sum_x  = flip_r ? (acc_x_r - prod_x) : (acc_x_r + prod_x);
  assign sum_y  = flip_r ? (acc_y_r - prod_y) : (acc_y_r + prod_y);

  // limits in mm with 16 fraction bits, x and y compared exactly
  assign lim_front = signed'({10'd0, front_r, 16'd0});
  assign lim_rear  = signed'({10'd0, rear_r,  16'd0});
  assign lim_left  = signed'({10'd0, left_r,  16'd0});
  assign lim_right = signed'({10'd0, right_r, 16'd0});
  assign in_box = (acc_x_r >= -lim_rear)  && (acc_x_r <= lim_front) &&
                  (acc_y_r >= -lim_right) && (acc_y_r <= lim_left);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= lfbf_pkg::FRONT_RST;
      rear_r      <= lfbf_pkg::REAR_RST;
      left_r      <= lfbf_pkg::LEFT_RST;
      right_r     <= lfbf_pkg::RIGHT_RST;
      start_ang_r <= lfbf_pkg::START_ANG_RST;
      ang_step_r  <= lfbf_pkg::ANG_STEP_RST;
      min_range_r <= lfbf_pkg::MIN_RANGE_RST;
      max_range_r <= lfbf_pkg::MAX_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lfbf_pkg::cfg_reg_t'(cfg_index))
        lfbf_pkg::REG_FRONT:     front_r     <= cfg_data;
        lfbf_pkg::REG_REAR:      rear_r      <= cfg_data;
        lfbf_pkg::REG_LEFT:      left_r      <= cfg_data;
        lfbf_pkg::REG_RIGHT:     right_r     <= cfg_data;
        lfbf_pkg::REG_START_ANG: start_ang_r <= cfg_data;
        lfbf_pkg::REG_ANG_STEP:  ang_step_r  <= cfg_data;
        lfbf_pkg::REG_MIN_RANGE: min_range_r <= cfg_data;
        lfbf_pkg::REG_MAX_RANGE: max_range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // beam angle offset, restarted after the last beam of a scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (in_acc) begin
      offset_r <= in_scan_end ? 16'd0 : (offset_r + ang_step_r);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfbf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = test_beam ? lfbf_pkg::ST_ROT : lfbf_pkg::ST_SEND;
        end
      end
      lfbf_pkg::ST_ROT: begin
        if (rot_last) state_nxt = lfbf_pkg::ST_MUL;
      end
      lfbf_pkg::ST_MUL: begin
        if (mul_last) state_nxt = lfbf_pkg::ST_CHK;
      end
      lfbf_pkg::ST_CHK: begin
        state_nxt = lfbf_pkg::ST_SEND;
      end
      lfbf_pkg::ST_SEND: begin
        if (out_acc) state_nxt = lfbf_pkg::ST_IDLE;
      end
      default: state_nxt = lfbf_pkg::ST_IDLE;
    endcase
  end

  // step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cnt_r <= '0;
      mul_cnt_r <= '0;
    end else begin
      if (state_r == lfbf_pkg::ST_ROT) begin
        rot_cnt_r <= rot_last ? '0 : (rot_cnt_r + 1'b1);
      end
      if (state_r == lfbf_pkg::ST_MUL) begin
        mul_cnt_r <= mul_last ? '0 : (mul_cnt_r + 1'b1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      lfbf_pkg::ST_IDLE: begin
        if (in_acc) begin
          flip_r  <= flip;
          x_r     <= signed'({4'd0, in_range_mm, 16'd0});
          y_r     <= '0;
          z_r     <= signed'({{2{ang_folded[15]}}, ang_folded, 16'd0});
        end
      end
      lfbf_pkg::ST_ROT: begin
        x_r <= x_step;
        y_r <= y_step;
        z_r <= z_step;
        if (rot_last) begin
          acc_x_r <= '0;
          acc_y_r <= '0;
        end
      end
      lfbf_pkg::ST_MUL: begin
        // shift out the used digit, shift the partial product down with it
        x_r     <= x_r >>> lfbf_pkg::DIGIT_W;
        y_r     <= y_r >>> lfbf_pkg::DIGIT_W;
        acc_x_r <= sum_x >>> lfbf_pkg::DIGIT_W;
        acc_y_r <= sum_y >>> lfbf_pkg::DIGIT_W;
      end
      default: ;
    endcase
  end

  // result register: loaded as a pass-through at acceptance, overwritten
  // when the point lands inside the box
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_range_mm_r   <= in_range_mm;
      out_range_kind_r <= in_range_kind;
      out_intensity_r  <= in_intensity;
      out_scan_end_r   <= in_scan_end;
    end else if (state_r == lfbf_pkg::ST_CHK && in_box) begin
      out_range_mm_r   <= '0;
      out_range_kind_r <= lfbf_pkg::KIND_POS_INF;
      out_intensity_r  <= '0;
    end
  end

endmodule

FILE: verif/lfbf_beam_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfbf_beam_checker
// watches the config, beam and result channels of the footprint box filter,
// keeps its own copy of the registers and beam angle, predicts every result
// and compares it field by field in order
// ----------------------------------------------------------------------------
module lfbf_beam_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lfbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [lfbf_pkg::RANGE_W-1:0]   in_range_mm,
  input  logic [lfbf_pkg::KIND_W-1:0]    in_range_kind,
  input  logic [lfbf_pkg::INTEN_W-1:0]   in_intensity,
  input  logic                           in_scan_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [lfbf_pkg::RANGE_W-1:0]   out_range_mm,
  input  logic [lfbf_pkg::KIND_W-1:0]    out_range_kind,
  input  logic [lfbf_pkg::INTEN_W-1:0]   out_intensity,
  input  logic                           out_scan_end,
  output int                             mismatches,
  output int                             beams_pending
);
  import lfbf_pkg::*;

  localparam longint GAIN_COMP_Q30 = 652032874;
  // arctangent of 2^-i, 2^32 units per turn
  localparam longint ATAN_BAM32 [0:23] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    range_kind_t        kind;
    logic [INTEN_W-1:0] intensity;
    logic               scan_end;
  } beam_t;

  logic [15:0] front_mm, rear_mm, left_mm, right_mm;
  logic [15:0] start_angle, angle_step, min_range, max_range;
  logic [15:0] angle_offset;
  beam_t       expected_beams[$];

  // rotate (r, 0) by the beam angle and test against the box
  function automatic bit beam_hits_footprint(logic [15:0] r, logic [15:0] ang);
    bit          flip;
    logic [15:0] folded;
    longint      x, y, z, dx, dy, xs, ys;
    // angles in the back half get a half-turn fold
    flip   = ang[15] ^ ang[14];
    folded = flip ? ang + 16'h8000 : ang;
    z = longint'($signed(folded));
    z = z * 65536;
    x = longint'(r) * 65536;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_BAM32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_BAM32[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    xs = (x * GAIN_COMP_Q30) >>> 30;
    ys = (y * GAIN_COMP_Q30) >>> 30;
    return xs >= -(longint'(rear_mm) * 65536) && xs <= longint'(front_mm) * 65536 &&
           ys >= -(longint'(right_mm) * 65536) && ys <= longint'(left_mm) * 65536;
  endfunction

  always @(posedge clk) begin
    beam_t       want;
    logic [15:0] beam_angle;
    if (!rst_n) begin
      front_mm     = FRONT_RST;
      rear_mm      = REAR_RST;
      left_mm      = LEFT_RST;
      right_mm     = RIGHT_RST;
      start_angle  = START_ANG_RST;
      angle_step   = ANG_STEP_RST;
      min_range    = MIN_RANGE_RST;
      max_range    = MAX_RANGE_RST;
      angle_offset = '0;
      expected_beams.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRONT:     front_mm    = cfg_data;
          REG_REAR:      rear_mm     = cfg_data;
          REG_LEFT:      left_mm     = cfg_data;
          REG_RIGHT:     right_mm    = cfg_data;
          REG_START_ANG: start_angle = cfg_data;
          REG_ANG_STEP:  angle_step  = cfg_data;
          REG_MIN_RANGE: min_range   = cfg_data;
          REG_MAX_RANGE: max_range   = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_beams.size() == 0) begin
          $error("filtered beam with no request pending");
          mismatches++;
        end else begin
          want = expected_beams.pop_front();
          if (out_range_mm !== want.range_mm) begin
            $error("out_range_mm: expected %0d, actual %0d", want.range_mm, out_range_mm);
            mismatches++;
          end
          if (out_range_kind !== want.kind) begin
            $error("out_range_kind: expected %0d, actual %0d", want.kind, out_range_kind);
            mismatches++;
          end
          if (out_intensity !== want.intensity) begin
            $error("out_intensity: expected %0d, actual %0d", want.intensity, out_intensity);
            mismatches++;
          end
          if (out_scan_end !== want.scan_end) begin
            $error("out_scan_end: expected %0d, actual %0d", want.scan_end, out_scan_end);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        beam_angle      = start_angle + angle_offset;
        want.range_mm   = in_range_mm;
        want.kind       = range_kind_t'(in_range_kind);
        want.intensity  = in_intensity;
        want.scan_end   = in_scan_end;
        if (want.kind == KIND_FINITE && in_range_mm >= min_range &&
            in_range_mm <= max_range && beam_hits_footprint(in_range_mm, beam_angle)) begin
          want.range_mm  = '0;
          want.kind      = KIND_POS_INF;
          want.intensity = '0;
        end
        expected_beams.push_back(want);
        angle_offset = in_scan_end ? 16'd0 : angle_offset + angle_step;
      end
    end
    beams_pending = expected_beams.size();
  end

endmodule

FILE: verif/lidar_footprint_box_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_footprint_box_filter_test
// drives scans of lidar beams through the footprint box filter under several
// box and angle settings, with random gaps and stalls on both channels; the
// beam checker predicts every filtered beam and counts mismatches
// ----------------------------------------------------------------------------
module lidar_footprint_box_filter_test;
  import lfbf_pkg::*;

  localparam int unsigned STEPS = 16;
  // drain time covers a tested beam's rotation, gain multiply and check, plus margin
  localparam int unsigned DRAIN_CYCLES = STEPS + 24;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RANGE_W-1:0]   in_range_mm = '0;
  logic [KIND_W-1:0]    in_range_kind = '0;
  logic [INTEN_W-1:0]   in_intensity = '0;
  logic                 in_scan_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [RANGE_W-1:0]   out_range_mm;
  logic [KIND_W-1:0]    out_range_kind;
  logic [INTEN_W-1:0]   out_intensity;
  logic                 out_scan_end;

  int mismatches;
  int beams_pending;
  int beams_out = 0;
  bit burst_mode = 1'b0;
  bit long_hold_done = 1'b0;

  always #5 clk = ~clk;

  lidar_footprint_box_filter #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_range_mm   (in_range_mm),
    .in_range_kind (in_range_kind),
    .in_intensity  (in_intensity),
    .in_scan_end   (in_scan_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_range_mm  (out_range_mm),
    .out_range_kind(out_range_kind),
    .out_intensity (out_intensity),
    .out_scan_end  (out_scan_end)
  );

  lfbf_beam_checker #(
    .CORDIC_STEPS(STEPS)
  ) beam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_range_mm   (in_range_mm),
    .in_range_kind (in_range_kind),
    .in_intensity  (in_intensity),
    .in_scan_end   (in_scan_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_range_mm  (out_range_mm),
    .out_range_kind(out_range_kind),
    .out_intensity (out_intensity),
    .out_scan_end  (out_scan_end),
    .mismatches    (mismatches),
    .beams_pending (beams_pending)
  );

  // count filtered beams so the long hold-off lands mid-run
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      beams_out <= beams_out + 1;
    end
  end

  // one config write, valid dropped again before the next one
  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let every outstanding beam come back before touching registers
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (beams_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_footprint(logic [15:0] front, logic [15:0] rear,
                                   logic [15:0] left, logic [15:0] right,
                                   logic [15:0] start, logic [15:0] step,
                                   logic [15:0] lo, logic [15:0] hi);
    wait_idle();
    write_reg(REG_FRONT, front);
    write_reg(REG_REAR, rear);
    write_reg(REG_LEFT, left);
    write_reg(REG_RIGHT, right);
    write_reg(REG_START_ANG, start);
    write_reg(REG_ANG_STEP, step);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
  endtask

  // hold the request until taken, then maybe idle a while
  task automatic send_beam(logic [15:0] r, range_kind_t kind, logic [15:0] inten,
                           logic last);
    int gap;
    int pick;
    @(negedge clk);
    in_valid      = 1'b1;
    in_range_mm   = r;
    in_range_kind = kind;
    in_intensity  = inten;
    in_scan_end   = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pick = $urandom_range(0, 99);
    if (burst_mode || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // whole scans with random content, now and then a stray end mark
  task automatic random_scans(int count);
    int          sent;
    int          len;
    int          pick;
    logic [15:0] r;
    range_kind_t kind;
    logic        last;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        // most ranges near the box so both outcomes show up
        if (pick < 60) r = 16'($urandom_range(0, 1500));
        else if (pick < 66) r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else r = 16'($urandom_range(0, 65535));
        kind = ($urandom_range(0, 9) < 8) ? KIND_FINITE : range_kind_t'($urandom_range(1, 3));
        last = (k == len - 1) || ($urandom_range(0, 49) == 0);
        send_beam(r, kind, 16'($urandom), last);
      end
      sent += len;
    end
    burst_mode = 1'b0;
  endtask

  task automatic random_footprint();
    program_footprint(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                      16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                      16'($urandom),
                      $urandom_range(0, 1) ? 16'($urandom_range(0, 1000)) : 16'($urandom),
                      16'($urandom_range(0, 200)), 16'($urandom_range(600, 65535)));
  endtask

  // receiver: short stalls mostly, some long ones, stretches of none,
  // and once a long hold-off so the block backs up into the sender
  initial begin : result_stalls
    int run;
    int stall;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && beams_out >= 200) begin
        long_hold_done = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        run   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(30, 80);
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        repeat (run) @(negedge clk);
        if (stall > 0) begin
          out_stall = 1'b1;
          repeat (stall) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: first beam points straight back, rear limit 250 mm
    send_beam(16'd0, KIND_FINITE, 16'hFFFF, 1'b0);     // sensor origin
    send_beam(16'd200, KIND_FINITE, 16'h1234, 1'b0);   // well inside
    send_beam(16'd249, KIND_FINITE, 16'hFFFF, 1'b0);
    send_beam(16'd251, KIND_FINITE, 16'h0001, 1'b0);   // just past the edge
    send_beam(16'hFFFF, KIND_FINITE, 16'hFFFF, 1'b0);  // farthest range
    send_beam(16'd100, KIND_POS_INF, 16'hAAAA, 1'b0);  // non-finite passes as is
    send_beam(16'd100, KIND_NEG_INF, 16'h5555, 1'b0);
    send_beam(16'hFFFF, KIND_NAN, 16'hFFFF, 1'b0);
    send_beam(16'd0, KIND_NAN, 16'h0000, 1'b0);
    send_beam(16'd120, KIND_FINITE, 16'h8000, 1'b1);   // end of scan
    send_beam(16'd120, KIND_FINITE, 16'h7FFF, 1'b0);   // angle back at start
    send_beam(16'd0, KIND_FINITE, 16'h0000, 1'b1);

    // range window edges
    program_footprint(16'd450, 16'd250, 16'd250, 16'd250, 16'h8000, 16'd0,
                      16'd100, 16'd200);
    send_beam(16'd99, KIND_FINITE, 16'h0F0F, 1'b0);
    send_beam(16'd100, KIND_FINITE, 16'hF0F0, 1'b0);
    send_beam(16'd200, KIND_FINITE, 16'h00FF, 1'b0);
    send_beam(16'd201, KIND_FINITE, 16'hFF00, 1'b1);

    // inverted window, nothing gets tested
    program_footprint(16'd450, 16'd250, 16'd250, 16'd250, 16'h8000, 16'd0,
                      16'd300, 16'd100);
    send_beam(16'd150, KIND_FINITE, 16'h3333, 1'b0);
    send_beam(16'd0, KIND_FINITE, 16'hCCCC, 1'b1);

    // widest box, largest step so the offset wraps every beam
    program_footprint(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
                      16'd0, 16'hFFFF);
    send_beam(16'hFFFF, KIND_FINITE, 16'hFFFF, 1'b0);
    send_beam(16'hFFFF, KIND_FINITE, 16'hFFFF, 1'b0);
    send_beam(16'd1, KIND_FINITE, 16'h0001, 1'b1);
    random_scans(80);

    random_footprint();
    random_scans(100);

    // zero box, zero step, window of range zero only
    program_footprint(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beam(16'd0, KIND_FINITE, 16'h1111, 1'b0);
    random_scans(50);

    // inverted window under random traffic
    program_footprint(16'd800, 16'd800, 16'd800, 16'd800, 16'h4000, 16'd300,
                      16'hFFFF, 16'd0);
    random_scans(40);

    random_footprint();
    random_scans(110);

    random_footprint();
    random_scans(110);

    // drain, then give the block time to show anything stray
    @(negedge clk);
    in_valid = 1'b0;
    while (beams_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lidar_footprint_box_filter verification clean");
    end else begin
      $display("lidar_footprint_box_filter verification failed");
    end
    $finish;
  end

  // hard limit, several times the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("lidar_footprint_box_filter verification failed");
    $finish;
  end

endmodule
